// ===== src/udta_pkg.sv =====
// ----------------------------------------------------------------------------
// udta_pkg
// Shared types and constants for the decimal ASCII converter.
// ----------------------------------------------------------------------------
package udta_pkg;

	// ASCII code of '0', as carried in the 6-bit character field
	localparam logic [5:0] ASCII_ZERO = 6'd48;

	// Width of the character field
	localparam int CHAR_BITS = 6;

	// Front-end sequencer states
	typedef enum logic [1:0] {
		FR_IDLE,
		FR_CONV,
		FR_PUSH
	} front_state_t;

	// Decimal digits needed for the largest value of a given bit width.
	// 1233/4096 approximates log10(2) closely enough up to 64 bits.
	function automatic int digits_for_bits(input int bits);
		return ((bits * 1233) >> 12) + 1;
	endfunction

endpackage

// ===== src/udta_front.sv =====
// ----------------------------------------------------------------------------
// udta_front
// Accepts one binary value, converts it to packed BCD with a bit-serial
// shift-and-add-3 loop, counts the significant digits and pushes the result.
// ----------------------------------------------------------------------------
module udta_front #(
	parameter int VALUE_BITS = 32,
	parameter int NDIG       = 10,
	parameter int NDW        = 4
) (
	input  logic                    clk,
	input  logic                    arst_n,
	input  logic                    in_valid,
	output logic                    in_ready,
	input  logic [VALUE_BITS-1:0]   in_value,
	output logic                    wr_valid,
	input  logic                    wr_ready,
	output logic [NDIG*4+NDW-1:0]   wr_data   // {digit count, packed BCD}
);
	import udta_pkg::*;

	localparam int CW = (VALUE_BITS > 1) ? $clog2(VALUE_BITS) : 1;
	localparam int BW = NDIG * 4;

	front_state_t state_q, state_d;
	logic [CW-1:0]         cnt_q;
	logic [VALUE_BITS-1:0] bin_q;
	logic [BW-1:0]         bcd_q;
	logic [BW-1:0]         bcd_adj;
	logic [NDW-1:0]        ndig;
	logic                  last_bit;

	// Add 3 to every nibble of 5 or more before the shift
	always_comb begin
		for (int i = 0; i < NDIG; i++) begin
			if (bcd_q[i*4 +: 4] >= 4'd5) begin
				bcd_adj[i*4 +: 4] = bcd_q[i*4 +: 4] + 4'd3;
			end else begin
				bcd_adj[i*4 +: 4] = bcd_q[i*4 +: 4];
			end
		end
	end

	// Significant digit count, at least one
	always_comb begin
		ndig = NDW'(1);
		for (int i = 1; i < NDIG; i++) begin
			if (bcd_q[i*4 +: 4] != 4'd0) begin
				ndig = NDW'(i + 1);
			end
		end
	end

	assign last_bit = (cnt_q == CW'(VALUE_BITS - 1));
	assign wr_data  = {ndig, bcd_q};

	// State register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= FR_IDLE;
		end else begin
			state_q <= state_d;
		end
	end

	// Next state and handshakes
	always_comb begin
		state_d  = state_q;
		in_ready = 1'b0;
		wr_valid = 1'b0;
		case (state_q)
			FR_IDLE: begin
				in_ready = 1'b1;
				if (in_valid) begin
					state_d = FR_CONV;
				end
			end
			FR_CONV: begin
				if (last_bit) begin
					state_d = FR_PUSH;
				end
			end
			FR_PUSH: begin
				wr_valid = 1'b1;
				if (wr_ready) begin
					state_d = FR_IDLE;
				end
			end
			default: begin
				state_d = FR_IDLE;
			end
		endcase
	end

	// Conversion datapath
	always_ff @(posedge clk) begin
		if (state_q == FR_IDLE && in_valid) begin
			bin_q <= in_value;
			bcd_q <= '0;
			cnt_q <= '0;
		end else if (state_q == FR_CONV) begin
			bcd_q <= {bcd_adj[BW-2:0], bin_q[VALUE_BITS-1]};
			bin_q <= {bin_q[VALUE_BITS-2:0], 1'b0};
			cnt_q <= cnt_q + 1'b1;
		end
	end

endmodule

// ===== src/udta_fifo.sv =====
// ----------------------------------------------------------------------------
// udta_fifo
// Two-entry queue between the converter and the character emitter.
// ----------------------------------------------------------------------------
module udta_fifo #(
	parameter int W = 44
) (
	input  logic         clk,
	input  logic         arst_n,
	input  logic         wr_valid,
	output logic         wr_ready,
	input  logic [W-1:0] wr_data,
	output logic         rd_valid,
	input  logic         rd_ready,
	output logic [W-1:0] rd_data
);
	import udta_pkg::*;

	logic [W-1:0] mem_q [2];
	logic         wr_ptr_q;
	logic         rd_ptr_q;
	logic [1:0]   count_q;
	logic         push;
	logic         pop;

	assign wr_ready = (count_q != 2'd2);
	assign rd_valid = (count_q != 2'd0);
	assign rd_data  = mem_q[rd_ptr_q];
	assign push     = wr_valid && wr_ready;
	assign pop      = rd_valid && rd_ready;

	// Pointers and fill count
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= 1'b0;
			rd_ptr_q <= 1'b0;
			count_q  <= 2'd0;
		end else begin
			if (push) begin
				wr_ptr_q <= ~wr_ptr_q;
			end
			if (pop) begin
				rd_ptr_q <= ~rd_ptr_q;
			end
			if (push && !pop) begin
				count_q <= count_q + 2'd1;
			end else if (pop && !push) begin
				count_q <= count_q - 2'd1;
			end
		end
	end

	// Storage
	always_ff @(posedge clk) begin
		if (push) begin
			mem_q[wr_ptr_q] <= wr_data;
		end
	end

endmodule

// ===== src/udta_back.sv =====
// ----------------------------------------------------------------------------
// udta_back
// Takes a BCD word with its digit count and sends its digits as ASCII
// characters, most significant first, marking the final one.
// ----------------------------------------------------------------------------
module udta_back #(
	parameter int NDIG = 10,
	parameter int NDW  = 4
) (
	input  logic                  clk,
	input  logic                  arst_n,
	input  logic                  rd_valid,
	output logic                  rd_ready,
	input  logic [NDIG*4+NDW-1:0] rd_data,
	output logic                  out_valid,
	input  logic                  out_ready,
	output logic [udta_pkg::CHAR_BITS-1:0] out_char,
	output logic                  out_last
);
	import udta_pkg::*;

	localparam int BW = NDIG * 4;
	localparam int IW = (NDIG > 1) ? $clog2(NDIG) : 1;

	logic                 busy_q;
	logic [NDW-1:0]       rem_q;
	logic [BW-1:0]        bcd_q;
	logic                 valid_q;
	logic [CHAR_BITS-1:0] char_q;
	logic                 last_q;
	logic                 advance;
	logic                 final_digit;
	logic [IW-1:0]        idx;
	logic [3:0]           digit;

	assign advance     = busy_q && (!valid_q || out_ready);
	assign final_digit = (rem_q == NDW'(1));
	assign rd_ready    = !busy_q || (advance && final_digit);
	assign idx         = IW'(rem_q - NDW'(1));
	assign digit       = bcd_q[idx*4 +: 4];

	assign out_valid = valid_q;
	assign out_char  = char_q;
	assign out_last  = last_q;

	// Control: word in progress and output register occupancy
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q  <= 1'b0;
			valid_q <= 1'b0;
		end else begin
			if (rd_valid && rd_ready) begin
				busy_q <= 1'b1;
			end else if (advance && final_digit) begin
				busy_q <= 1'b0;
			end
			if (advance) begin
				valid_q <= 1'b1;
			end else if (out_ready) begin
				valid_q <= 1'b0;
			end
		end
	end

	// Payload: load a word, then step down one digit per sent character
	always_ff @(posedge clk) begin
		if (rd_valid && rd_ready) begin
			bcd_q <= rd_data[BW-1:0];
			rem_q <= rd_data[BW +: NDW];
		end else if (advance) begin
			rem_q <= rem_q - NDW'(1);
		end
		if (advance) begin
			char_q <= ASCII_ZERO + CHAR_BITS'(digit);
			last_q <= final_digit;
		end
	end

endmodule

// ===== src/unsigned_decimal_to_ascii_unit.sv =====
// ----------------------------------------------------------------------------
// unsigned_decimal_to_ascii_unit
// Unsigned binary to decimal ASCII text, one character per output word.
// ----------------------------------------------------------------------------
// Each input word carries an unsigned number; its low VALUE_BITS bits are
// converted and sent out as decimal ASCII digits, most significant first,
// with no leading zeros (zero gives a single '0'), and tlast set on the
// final digit. Each word takes a load, one shift-and-add-3 step per input
// bit and a hand-off in the converter, which sets the sustained rate; the converter
// takes no new word until the last is handed off. The emitter sends one
// character per cycle while m_tready is high, from a two-entry queue, so a
// new word is converted while the previous number's characters still drain.
module unsigned_decimal_to_ascii_unit #(
	parameter int VALUE_BITS = 32
) (
	input  logic                                  clk,
	input  logic                                  arst_n,
	input  logic                                  s_tvalid,
	output logic                                  s_tready,
	input  logic [((VALUE_BITS+7)/8)*8-1:0]       s_tdata,  // value
	output logic                                  m_tvalid,
	input  logic                                  m_tready,
	output logic [7:0]                            m_tdata,  // 2'b0, digit_char
	output logic                                  m_tlast
);
	import udta_pkg::*;

	localparam int NDIG = digits_for_bits(VALUE_BITS);
	localparam int NDW  = $clog2(NDIG + 1);
	localparam int QW   = NDIG * 4 + NDW;

	logic                 q_wr_valid;
	logic                 q_wr_ready;
	logic [QW-1:0]        q_wr_data;
	logic                 q_rd_valid;
	logic                 q_rd_ready;
	logic [QW-1:0]        q_rd_data;
	logic [CHAR_BITS-1:0] out_char;

	// Converter
	udta_front #(
		.VALUE_BITS(VALUE_BITS),
		.NDIG      (NDIG),
		.NDW       (NDW)
	) u_front (
		.clk     (clk),
		.arst_n  (arst_n),
		.in_valid(s_tvalid),
		.in_ready(s_tready),
		.in_value(s_tdata[VALUE_BITS-1:0]),
		.wr_valid(q_wr_valid),
		.wr_ready(q_wr_ready),
		.wr_data (q_wr_data)
	);

	// Queue between converter and emitter
	udta_fifo #(
		.W(QW)
	) u_fifo (
		.clk     (clk),
		.arst_n  (arst_n),
		.wr_valid(q_wr_valid),
		.wr_ready(q_wr_ready),
		.wr_data (q_wr_data),
		.rd_valid(q_rd_valid),
		.rd_ready(q_rd_ready),
		.rd_data (q_rd_data)
	);

	// Character emitter
	udta_back #(
		.NDIG(NDIG),
		.NDW (NDW)
	) u_back (
		.clk      (clk),
		.arst_n   (arst_n),
		.rd_valid (q_rd_valid),
		.rd_ready (q_rd_ready),
		.rd_data  (q_rd_data),
		.out_valid(m_tvalid),
		.out_ready(m_tready),
		.out_char (out_char),
		.out_last (m_tlast)
	);

	assign m_tdata = {2'b00, out_char};

endmodule

// ===== test/unsigned_decimal_to_ascii_unit_chk.sv =====
// ----------------------------------------------------------------------------
// unsigned_decimal_to_ascii_unit_chk
// Watches both streams of the decimal ASCII converter and scores its output.
// ----------------------------------------------------------------------------
// Every accepted input word is turned into the decimal text it should give,
// one character per entry, most significant digit first. Every accepted
// output word is compared with the oldest pending character: code, tlast
// flag and the zero pad above the code. The error count and the number of
// characters still owed go back to the testbench top.
module unsigned_decimal_to_ascii_unit_chk #(
	parameter int VALUE_BITS = 32,
	parameter int TDATA_W    = ((VALUE_BITS+7)/8)*8
) (
	input  logic               clk,
	input  logic               arst_n,
	input  logic               s_tvalid,
	input  logic               s_tready,
	input  logic [TDATA_W-1:0] s_tdata,   // value
	input  logic               m_tvalid,
	input  logic               m_tready,
	input  logic [7:0]         m_tdata,   // 2'b0, digit_char
	input  logic               m_tlast,
	output int                 errors,
	output int                 pending,
	output int                 numbers_in,
	output int                 chars_out
);
	timeunit 1ns;
	timeprecision 1ps;

	import udta_pkg::*;

	typedef struct packed {
		logic [CHAR_BITS-1:0] code;
		logic                 last;
	} text_char_t;

	typedef text_char_t text_q_t[$];

	// Characters still owed by the block, oldest first
	text_q_t owed_chars;

	// Decimal text of the low VALUE_BITS bits of a number, no leading zeros
	function automatic text_q_t decimal_text(input logic [63:0] num);
		text_q_t    text;
		text_char_t ch;
		logic [63:0] rest;
		logic [63:0] digit;
		rest = num;
		if (VALUE_BITS < 64)
			rest = num & ((64'd1 << VALUE_BITS) - 64'd1);
		// digits come out least significant first, so build from the back
		do begin
			digit   = rest % 64'd10;
			ch.code = ASCII_ZERO + CHAR_BITS'(digit);
			ch.last = (text.size() == 0);
			text.push_front(ch);
			rest    = rest / 64'd10;
		end while (rest != 64'd0);
		return text;
	endfunction

	// Predict on input words, score output words
	always @(posedge clk or negedge arst_n) begin
		text_q_t    text;
		text_char_t want;
		int         bad;
		if (!arst_n) begin
			owed_chars.delete();
			errors     <= 0;
			pending    <= 0;
			numbers_in <= 0;
			chars_out  <= 0;
		end else begin
			bad = 0;
			if (s_tvalid && s_tready) begin
				text = decimal_text(64'(s_tdata));
				foreach (text[i])
					owed_chars.push_back(text[i]);
				numbers_in <= numbers_in + 1;
			end
			if (m_tvalid && m_tready) begin
				chars_out <= chars_out + 1;
				if (owed_chars.size() == 0) begin
					$error("unexpected output word: m_tdata=%0d m_tlast=%0b",
						m_tdata, m_tlast);
					bad++;
				end else begin
					want = owed_chars.pop_front();
					if (m_tdata[5:0] !== want.code) begin
						$error("digit_char: expected %0d, got %0d", want.code, m_tdata[5:0]);
						bad++;
					end
					if (m_tlast !== want.last) begin
						$error("last: expected %0b, got %0b", want.last, m_tlast);
						bad++;
					end
					if (m_tdata[7:6] !== 2'b00) begin
						$error("pad: expected 0, got %0d", m_tdata[7:6]);
						bad++;
					end
				end
			end
			if (bad != 0)
				errors <= errors + bad;
			pending <= owed_chars.size();
		end
	end

endmodule

// ===== test/unsigned_decimal_to_ascii_unit_tb.sv =====
// ----------------------------------------------------------------------------
// unsigned_decimal_to_ascii_unit_tb
// Stimulus and verdict for the decimal ASCII converter.
// ----------------------------------------------------------------------------
// Feeds a directed set of numbers (zero, all ones, powers of ten and their
// neighbors, alternating bit patterns) and then a few hundred random ones,
// weighted so that every text length from one to ten digits shows up.
// Both streams idle at random; two pauses let the output drain completely.
// Scoring happens in the checker instantiated next to the block.
module unsigned_decimal_to_ascii_unit_tb;
	timeunit 1ns;
	timeprecision 1ps;

	localparam int VALUE_BITS   = 32;
	localparam int TDATA_W      = ((VALUE_BITS+7)/8)*8;
	localparam int RANDOM_WORDS = 420;
	localparam int CYCLE_LIMIT  = 1500000;
	localparam int DRAIN_CYCLES = VALUE_BITS + 24;

	logic               clk;
	logic               arst_n;
	logic               s_tvalid;
	logic               s_tready;
	logic [TDATA_W-1:0] s_tdata;   // value
	logic               m_tvalid;
	logic               m_tready;
	logic [7:0]         m_tdata;   // 2'b0, digit_char
	logic               m_tlast;

	int errors;
	int pending;
	int numbers_in;
	int chars_out;
	int cycles;
	bit steady_send;

	unsigned_decimal_to_ascii_unit #(
		.VALUE_BITS(VALUE_BITS)
	) i_dut (
		.clk     (clk),
		.arst_n  (arst_n),
		.s_tvalid(s_tvalid),
		.s_tready(s_tready),
		.s_tdata (s_tdata),
		.m_tvalid(m_tvalid),
		.m_tready(m_tready),
		.m_tdata (m_tdata),
		.m_tlast (m_tlast)
	);

	unsigned_decimal_to_ascii_unit_chk #(
		.VALUE_BITS(VALUE_BITS)
	) i_chk (
		.clk       (clk),
		.arst_n    (arst_n),
		.s_tvalid  (s_tvalid),
		.s_tready  (s_tready),
		.s_tdata   (s_tdata),
		.m_tvalid  (m_tvalid),
		.m_tready  (m_tready),
		.m_tdata   (m_tdata),
		.m_tlast   (m_tlast),
		.errors    (errors),
		.pending   (pending),
		.numbers_in(numbers_in),
		.chars_out (chars_out)
	);

	// 4 ns clock
	initial clk = 1'b0;
	always begin
		#2 clk = 1'b1;
		#2 clk = 1'b0;
	end

	// Run limit
	initial cycles = 0;
	always @(posedge clk) begin
		cycles <= cycles + 1;
		if (cycles > CYCLE_LIMIT) begin
			$display("Some tests failed");
			$finish;
		end
	end

	// Random sink stalls: short ones mostly, a few long, some long open stretches
	initial begin
		int hold;
		hold     = 0;
		m_tready = 1'b0;
		forever begin
			@(negedge clk);
			if (hold > 0) begin
				hold--;
			end else begin
				case ($urandom_range(0, 9))
					0: begin
						m_tready <= 1'b1;
						hold = $urandom_range(60, 200);
					end
					1, 2, 3, 4, 5: begin
						m_tready <= 1'b1;
						hold = $urandom_range(0, 12);
					end
					6, 7, 8: begin
						m_tready <= 1'b0;
						hold = $urandom_range(0, 3);
					end
					default: begin
						m_tready <= 1'b0;
						hold = $urandom_range(20, 40);
					end
				endcase
			end
		end
	end

	// Source gap length: none in steady stretches, else mostly short
	function automatic int source_gap();
		int r;
		if (steady_send)
			return 0;
		r = $urandom_range(0, 99);
		if (r < 55)
			return 0;
		else if (r < 90)
			return $urandom_range(1, 3);
		return $urandom_range(20, 50);
	endfunction

	// Offer one word and hold it until it is taken
	task automatic send_number(input logic [TDATA_W-1:0] num);
		@(negedge clk);
		s_tvalid <= 1'b1;
		s_tdata  <= num;
		do
			@(posedge clk);
		while (!s_tready);
	endtask

	// Drop valid for a number of cycles; zero keeps the stream back to back
	task automatic source_idle(input int n);
		if (n > 0) begin
			@(negedge clk);
			s_tvalid <= 1'b0;
			s_tdata  <= TDATA_W'($urandom);
			repeat (n - 1) @(negedge clk);
		end
	endtask

	// Hold off the source until every owed character is out
	task automatic wait_drained();
		source_idle(1);
		while (pending != 0)
			@(posedge clk);
	endtask

	// Random number with a random decimal length, near a power of ten, or any 32-bit value
	function automatic logic [31:0] random_number();
		int unsigned span;
		int          len;
		int          r;
		r = $urandom_range(0, 99);
		if (r < 45) begin
			len  = $urandom_range(1, 10);
			span = 1;
			repeat (len) span = span * 10;
			if (len == 10)
				return $urandom;
			return $urandom % span;
		end else if (r < 65) begin
			len  = $urandom_range(1, 9);
			span = 1;
			repeat (len) span = span * 10;
			return span + $urandom_range(0, 2) - 1;
		end
		return $urandom;
	endfunction

	// Stimulus
	initial begin
		logic [31:0] directed_numbers[$];
		arst_n      = 1'b0;
		s_tvalid    = 1'b0;
		s_tdata     = '0;
		steady_send = 1'b0;
		directed_numbers = '{
			32'd0, 32'd1, 32'd9, 32'd10, 32'd11, 32'd99, 32'd100, 32'd999,
			32'd1000, 32'd12345, 32'd65535, 32'd65536, 32'd9876543,
			32'd999999999, 32'd1000000000, 32'd1000000001, 32'd1234567890,
			32'd2147483647, 32'd2147483648, 32'd4000000000, 32'd4294967294,
			32'd4294967295, 32'h55555555, 32'hAAAAAAAA
		};
		repeat (9) @(negedge clk);
		arst_n = 1'b1;
		repeat (2) @(negedge clk);

		// directed: extremes, digit count boundaries, bit patterns
		foreach (directed_numbers[i]) begin
			send_number(TDATA_W'(directed_numbers[i]));
			source_idle(source_gap());
		end
		wait_drained();

		// random part, with back-to-back stretches and one full drain midway
		for (int i = 0; i < RANDOM_WORDS; i++) begin
			steady_send = (i % 100) >= 70;
			if (i == RANDOM_WORDS / 2)
				wait_drained();
			send_number(TDATA_W'(random_number()));
			source_idle(source_gap());
		end
		source_idle(1);

		// let everything drain, then watch a while for stray words
		while (pending != 0)
			@(posedge clk);
		repeat (DRAIN_CYCLES) @(posedge clk);

		$display("Converted %0d numbers into %0d characters, directed edge values plus",
			numbers_in, chars_out);
		$display("random lengths of one to ten digits under random stalls on both sides.");
		if (errors == 0) begin
			$display("All tests passed");
		end else begin
			$display("Some tests failed");
		end
		$finish;
	end

endmodule

// ===== unsigned_decimal_to_ascii_unit.f =====
src/udta_pkg.sv
src/udta_front.sv
src/udta_fifo.sv
src/udta_back.sv
src/unsigned_decimal_to_ascii_unit.sv
test/unsigned_decimal_to_ascii_unit_chk.sv
test/unsigned_decimal_to_ascii_unit_tb.sv
